/* hw/rtl/sst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// shared constants for the sorted set table: field widths, request and
// status codes, default table capacity
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SST_CAPACITY = 256;

    localparam int KEY_W   = 32;
    localparam int REQ_W   = 2;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 9;

    // result transaction payload: found, position, status, entry_total
    localparam int RES_W   = 1 + POS_W + STAT_W + TOTAL_W;
    localparam int RES_PAD = ((RES_W + 7) / 8) * 8;

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_req REQ_QUERY  = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_DELETE = 2'd2;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_DUP    = 2'd1;
    localparam t_status STAT_ABSENT = 2'd2;
    localparam t_status STAT_FULL   = 2'd3;

endpackage
`default_nettype wire

/* hw/rtl/sorted_set_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_table
// ascending set of distinct signed 32-bit keys in one synchronous memory;
// serves query, insert and delete requests by binary search plus an
// entry-by-entry shift for insert and delete
// ----------------------------------------------------------------------------
//
//  channel   direction  ports                           payload
//  --------  ---------  ------------------------------  -----------------------------
//  request   in         i_s_tvalid/o_s_tready/tdata/    tdata: key, tuser: req_type
//                       i_s_tuser
//  result    out        o_m_tvalid/i_m_tready/o_m_tdata found, position, status,
//                                                       entry_total
//
//  flow: one request at a time; a search step is one memory read plus one
//    compare, for at most ceil(log2(n+1)) steps with n stored keys, then a
//    decide step once the window is empty; an insert or delete then moves
//    every later entry through the single read and write port
//  other states: ST_IDLE takes the request and ST_DONE loads the result register
//  reset: synchronous, active low; the key memory itself is not cleared, only
//    the entry count; entries at or above the count are never read
//  stalls: the result register frees the request side, so a new request is
//    taken while the previous result still waits on i_m_tready
//
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = SST_CAPACITY
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // request channel
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire  [KEY_W-1:0]    i_s_tdata,   // [31:0] key
    input  wire  [REQ_W-1:0]    i_s_tuser,   // [1:0] req_type
    // result channel
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [RES_PAD-1:0]  o_m_tdata    // [0] found, [8:1] position,
                                             // [10:9] status, [19:11] entry_total
);

    localparam int CW = $clog2(CAPACITY + 1);   // entry count width
    localparam int IW = $clog2(CAPACITY);       // table index width

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a request transaction
        ST_RD,      // issue a search read, or decide once the window is empty
        ST_CMP,     // compare the read key and narrow the window
        ST_MOVE,    // shift entries up (insert) or down (delete)
        ST_DONE     // load the result register
    } t_state;

    t_state                  r_state;

    // request
    t_req                    r_type;
    logic signed [KEY_W-1:0] r_key;

    // search window [lo, hi)
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [IW-1:0]           r_mid;
    logic                    r_found;

    // shift engine
    logic                    r_ins;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           r_src;
    logic [CW-1:0]           r_left;
    logic                    r_mv_valid;
    logic [IW-1:0]           r_mv_dst;

    logic [CW-1:0]           r_count;

    // result held for the output
    logic                    r_res_found;
    logic [POS_W-1:0]        r_res_pos;
    t_status                 r_res_status;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [POS_W-1:0]        r_out_pos;
    t_status                 r_out_status;
    logic [TOTAL_W-1:0]      r_out_total;

    // key memory, one read and one write port, registered read data
    logic signed [KEY_W-1:0] r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rd_data;

    logic                    w_re;
    logic [IW-1:0]           w_ra;
    logic                    w_we;
    logic [IW-1:0]           w_wa;
    logic signed [KEY_W-1:0] w_wd;

    logic [CW-1:0]           w_mid;
    logic                    w_window;
    logic [31:0]             w_lo_wide;
    logic [31:0]             w_count_wide;
    logic [CW-1:0]           w_count_m1;
    logic [CW-1:0]           w_lo_p1;
    logic                    w_full;
    logic                    w_is_ins;
    logic                    w_is_del;
    logic                    w_accept;
    logic                    w_load;

    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_window     = r_lo < r_hi;
    assign w_mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign w_lo_wide    = 32'(r_lo);
    assign w_count_wide = 32'(r_count);
    assign w_count_m1   = r_count - CW'(1);
    assign w_lo_p1      = r_lo + CW'(1);
    assign w_full       = r_count == CW'(CAPACITY);
    // unused request code behaves as a query
    assign w_is_ins     = r_type == REQ_INSERT;
    assign w_is_del     = r_type == REQ_DELETE;
    // result register takes the finished request
    assign w_load       = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    assign o_s_tready   = r_state == ST_IDLE;
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = RES_PAD'({r_out_total, r_out_status, r_out_pos, r_out_found});

    // memory port control
    always_comb begin
        w_re = 1'b0;
        w_ra = r_src;
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = r_key;
        if (r_state == ST_RD) begin
            w_re = w_window;
            w_ra = w_mid[IW-1:0];
        end else if (r_state == ST_MOVE) begin
            w_re = r_left != '0;
            // pending move write first, the new key goes in once the pipe is empty
            if (r_mv_valid) begin
                w_we = 1'b1;
                w_wa = r_mv_dst;
                w_wd = r_rd_data;
            end else if (r_left == '0 && r_ins) begin
                w_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_type  <= i_s_tuser;
                        r_key   <= $signed(i_s_tdata);
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_found <= 1'b0;
                        r_state <= ST_RD;
                    end
                end

                ST_RD: begin
                    if (w_window) begin
                        r_mid   <= w_mid[IW-1:0];
                        r_state <= ST_CMP;
                    end else begin
                        // r_lo is the lower bound of the key
                        r_idx       <= r_lo[IW-1:0];
                        r_res_found <= r_found;
                        r_ins       <= w_is_ins;
                        // a duplicate insert wins over a full table
                        if (w_is_ins && r_found) begin
                            r_res_pos    <= w_lo_wide[POS_W-1:0];
                            r_res_status <= STAT_DUP;
                            r_state      <= ST_DONE;
                        end else if (w_is_ins && w_full) begin
                            r_res_pos    <= '0;
                            r_res_status <= STAT_FULL;
                            r_state      <= ST_DONE;
                        end else if (w_is_ins) begin
                            r_res_pos    <= w_lo_wide[POS_W-1:0];
                            r_res_status <= STAT_OK;
                            r_left       <= r_count - r_lo;
                            r_src        <= w_count_m1[IW-1:0];
                            r_state      <= ST_MOVE;
                        end else if (!r_found) begin
                            // absent key on a query, a delete or the unused code
                            r_res_pos    <= '0;
                            r_res_status <= STAT_ABSENT;
                            r_state      <= ST_DONE;
                        end else if (w_is_del) begin
                            r_res_pos    <= w_lo_wide[POS_W-1:0];
                            r_res_status <= STAT_OK;
                            r_left       <= w_count_m1 - r_lo;
                            r_src        <= w_lo_p1[IW-1:0];
                            r_state      <= ST_MOVE;
                        end else begin
                            r_res_pos    <= w_lo_wide[POS_W-1:0];
                            r_res_status <= STAT_OK;
                            r_state      <= ST_DONE;
                        end
                    end
                end

                ST_CMP: begin
                    if (r_rd_data < r_key) begin
                        r_lo <= CW'(r_mid) + CW'(1);
                    end else begin
                        r_hi <= CW'(r_mid);
                    end
                    if (r_rd_data == r_key) begin
                        r_found <= 1'b1;
                    end
                    r_state <= ST_RD;
                end

                ST_MOVE: begin
                    if (r_left != '0) begin
                        r_mv_valid <= 1'b1;
                        r_mv_dst   <= r_ins ? r_src + IW'(1) : r_src - IW'(1);
                        r_src      <= r_ins ? r_src - IW'(1) : r_src + IW'(1);
                        r_left     <= r_left - CW'(1);
                    end else begin
                        r_mv_valid <= 1'b0;
                        if (!r_mv_valid) begin
                            r_count <= r_ins ? r_count + CW'(1) : w_count_m1;
                            r_state <= ST_DONE;
                        end
                    end
                end

                ST_DONE: begin
                    if (w_load) begin
                        r_out_found  <= r_res_found;
                        r_out_pos    <= r_res_pos;
                        r_out_status <= r_res_status;
                        r_out_total  <= w_count_wide[TOTAL_W-1:0];
                        r_state      <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == ST_MOVE)
        else $error("memory write outside the shift phase");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_MOVE |=> r_count == $past(r_count))
        else $error("entry count changed outside the shift phase");

    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CMP |-> r_lo < r_hi && r_hi <= r_count)
        else $error("search compare with an empty or oversized window");

    a_move_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_valid |-> r_state == ST_MOVE)
        else $error("pending move write outside the shift phase");

endmodule
`default_nettype wire

/* bench/sorted_set_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_table_tb
// self-checking bench for the sorted set table: a mirror of the key set in a
// queue predicts found, position, status and entry count for every request
// transaction; traffic goes from a short directed run to grow, shrink and
// mixed random phases with random idling on both streams and one long
// result-side hold-off
// ----------------------------------------------------------------------------
module sorted_set_table_tb
    import sst_pkg::*;
();

    // spare request code, served like a query
    localparam t_req REQ_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 400;    // longer than a full-table shift
    localparam int HOLD_AT      = 700;    // result count where the long hold-off starts
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        t_status            status;
        logic [TOTAL_W-1:0] entry_total;
    } t_lookup_result;

    // mirror of the stored keys plus the results still owed by the block
    class key_set_ledger;
        logic signed [KEY_W-1:0] held_keys[$];
        t_lookup_result          pending_results[$];
        int                      error_count;

        function new();
            error_count = 0;
        endfunction

        // first slot whose key is not below k
        function int lower_slot(logic signed [KEY_W-1:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = held_keys.size();
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (held_keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void note_request(t_req req, logic signed [KEY_W-1:0] k);
            t_lookup_result res;
            int             slot;
            bit             hit;
            slot = lower_slot(k);
            hit  = (slot < held_keys.size()) && (held_keys[slot] == k);
            res.found    = hit;
            res.position = '0;
            res.status   = STAT_OK;
            case (req)
                REQ_INSERT: begin
                    if (hit) begin
                        res.position = POS_W'(slot);
                        res.status   = STAT_DUP;
                    end else if (held_keys.size() >= SST_CAPACITY) begin
                        res.status = STAT_FULL;
                    end else begin
                        held_keys.insert(slot, k);
                        res.position = POS_W'(slot);
                    end
                end
                REQ_DELETE: begin
                    if (hit) begin
                        held_keys.delete(slot);
                        res.position = POS_W'(slot);
                    end else begin
                        res.status = STAT_ABSENT;
                    end
                end
                default: begin
                    if (hit) begin
                        res.position = POS_W'(slot);
                    end else begin
                        res.status = STAT_ABSENT;
                    end
                end
            endcase
            res.entry_total = TOTAL_W'(held_keys.size());
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [RES_PAD-1:0] data);
            t_lookup_result want;
            t_lookup_result got;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request outstanding: %h", data);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            got.found       = data[0];
            got.position    = data[POS_W:1];
            got.status      = data[POS_W+STAT_W:POS_W+1];
            got.entry_total = data[RES_W-1:POS_W+STAT_W+1];
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                error_count++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                error_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
            if (got.entry_total !== want.entry_total) begin
                $error("entry_total: expected %0d, got %0d",
                       want.entry_total, got.entry_total);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [KEY_W-1:0]   i_s_tdata;     // [31:0] key
    logic [REQ_W-1:0]   i_s_tuser;     // [1:0] req_type
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [RES_PAD-1:0] o_m_tdata;     // [0] found, [8:1] position, [10:9] status,
                                       // [19:11] entry_total

    key_set_ledger ledger;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            results_seen;
    int            hold_left;
    bit            hold_done;
    int            cycle_count;

    sorted_set_table #(
        .CAPACITY (SST_CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // run guard
    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: checks each accepted transaction, random back-pressure,
    // and one long hold-off so the block fills up and stalls its request side
    initial begin
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            ledger.check_result(o_m_tdata);
            results_seen++;
        end
        if (results_seen == HOLD_AT && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one request transaction, with random idle cycles ahead of it
    task automatic send_request(input t_req req, input logic signed [KEY_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tuser  <= req;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        ledger.note_request(req, key);
    endtask

    // key source: a stored key, a wide random key, a small key or an extreme
    function automatic logic signed [KEY_W-1:0] pick_key(int stored_pct);
        int pick;
        if (ledger.held_keys.size() != 0 && $urandom_range(99) < stored_pct) begin
            return ledger.held_keys[$urandom_range(ledger.held_keys.size() - 1)];
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            return $urandom;
        end else if (pick < 93) begin
            return $signed($urandom_range(16)) - 8;
        end
        case ($urandom_range(5))
            0: return KEY_MIN;
            1: return KEY_MIN + 1;
            2: return KEY_MAX;
            3: return KEY_MAX - 1;
            4: return 0;
            default: return -1;
        endcase
    endfunction

    // random requests with the given percentage mix, the rest spare codes
    task automatic run_random(input int count, input int w_ins, input int w_del,
                              input int w_qry);
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < w_ins) begin
                send_request(REQ_INSERT, pick_key(5));
            end else if (r < w_ins + w_del) begin
                send_request(REQ_DELETE, pick_key(85));
            end else if (r < w_ins + w_del + w_qry) begin
                send_request(REQ_QUERY, pick_key(50));
            end else begin
                send_request(REQ_SPARE, pick_key(50));
            end
        end
    endtask

    initial begin
        ledger = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= REQ_QUERY;
        i_m_tready <= 1'b0;
        tx_idle_pct = 10;
        rx_idle_pct = 80;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: every lookup misses
        send_request(REQ_QUERY, 0);
        send_request(REQ_DELETE, 5);
        send_request(REQ_SPARE, 7);
        // extremes and alternating bit patterns
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, 1);
        send_request(REQ_INSERT, 32'sh5555_5555);
        send_request(REQ_INSERT, 32'shAAAA_AAAA);
        send_request(REQ_INSERT, KEY_MIN);    // duplicate
        send_request(REQ_QUERY, KEY_MAX);     // last slot
        send_request(REQ_QUERY, KEY_MIN);     // first slot
        send_request(REQ_QUERY, 2);           // falls between two keys
        send_request(REQ_SPARE, 1);           // spare code on a present key
        send_request(REQ_DELETE, KEY_MIN);    // first entry
        send_request(REQ_DELETE, KEY_MAX);    // last entry
        send_request(REQ_DELETE, 0);          // middle entry
        send_request(REQ_DELETE, 0);          // already gone
        send_request(REQ_QUERY, 0);
        send_request(REQ_DELETE, -1);
        send_request(REQ_INSERT, KEY_MAX - 1);
        send_request(REQ_QUERY, KEY_MIN);

        // grow until the table is full and inserts get refused
        run_random(380, 95, 2, 3);
        tx_idle_pct = 80;
        rx_idle_pct = 10;
        // shrink, mostly deletes of stored keys
        run_random(260, 15, 70, 12);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // mixed traffic, the long hold-off lands here
        run_random(200, 30, 30, 35);
        i_s_tvalid <= 1'b0;

        while (ledger.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
